// ===== hw/rtl/utd_pkg.sv =====
`default_nettype none

package utd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned CONT_W  = 6;

    localparam logic [CP_W-1:0] SURR_LO = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI = 31'h0000_DFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_SURROGATE = 2'd3
    } status_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            final_res;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_to_utf32_decoder_unit.sv =====
// UTF-8 to UTF-32 decoder, one byte per beat, with the legacy 5- and 6-byte forms.
// A result is registered and appears on the master side in the cycle after its completing byte.
// Throughput: one byte per cycle, set by the single decode stage and its output register.
// A held result does not stop input unless the master side stalls with it still full.
// Reset (rst_n low, asynchronous) closes any open sequence, clears the skip state
// and empties the output register.
`default_nettype none

module utf8_to_utf32_decoder_unit
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] byte_in
    input  wire logic          s_tlast,

    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // [30:0] code_point, [31] zero
    output logic [1:0]         m_tuser,   // [1:0] status
    output logic               m_tlast
);

    logic               accept;
    logic               res_valid;
    utd_pkg::result_t   res;
    utd_pkg::result_t   out_res;

    assign accept = s_tvalid && s_tready;

    utd_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_in       (s_tdata),
        .end_of_string (s_tlast),
        .res_valid     (res_valid),
        .res           (res)
    );

    utd_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res.code_point};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.final_res;

endmodule

`default_nettype wire

// ===== hw/rtl/utd_core.sv =====
`default_nettype none

module utd_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [utd_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                         end_of_string,
    output logic                              res_valid,
    output utd_pkg::result_t                  res
);

    logic [utd_pkg::LEN_W-1:0]  seq_length_reg;
    logic [utd_pkg::LEN_W-1:0]  seq_length_next;
    logic [utd_pkg::LEN_W-1:0]  bytes_taken_reg;
    logic [utd_pkg::LEN_W-1:0]  bytes_taken_next;
    logic [utd_pkg::CP_W-1:0]   payload_acc_reg;
    logic [utd_pkg::CP_W-1:0]   payload_acc_next;
    logic                       halted_reg;
    logic                       halted_next;

    logic [utd_pkg::LEN_W-1:0]  lead_len;
    logic [utd_pkg::CP_W-1:0]   lead_bits;
    logic                       lead_bad;
    logic [utd_pkg::CP_W-1:0]   acc_shift;
    logic [utd_pkg::LEN_W-1:0]  taken_inc;

    always_comb
    begin
        lead_len  = '0;
        lead_bits = '0;
        lead_bad  = 1'b0;
        priority if ((byte_in & 8'he0) == 8'hc0)
        begin
            lead_len  = 3'd2;
            lead_bits = {26'd0, byte_in[4:0]};
        end
        else if ((byte_in & 8'hf0) == 8'he0)
        begin
            lead_len  = 3'd3;
            lead_bits = {27'd0, byte_in[3:0]};
        end
        else if ((byte_in & 8'hf8) == 8'hf0)
        begin
            lead_len  = 3'd4;
            lead_bits = {28'd0, byte_in[2:0]};
        end
        else if ((byte_in & 8'hfc) == 8'hf8)
        begin
            lead_len  = 3'd5;
            lead_bits = {29'd0, byte_in[1:0]};
        end
        else if ((byte_in & 8'hfe) == 8'hfc)
        begin
            lead_len  = 3'd6;
            lead_bits = {30'd0, byte_in[0]};
        end
        else
        begin
            lead_bad = 1'b1;
        end
    end

    assign acc_shift = {payload_acc_reg[utd_pkg::CP_W-utd_pkg::CONT_W-1:0],
                        byte_in[utd_pkg::CONT_W-1:0]};
    assign taken_inc = bytes_taken_reg + 3'd1;

    always_comb
    begin
        seq_length_next     = seq_length_reg;
        bytes_taken_next    = bytes_taken_reg;
        payload_acc_next    = payload_acc_reg;
        halted_next         = halted_reg;
        res_valid           = 1'b0;
        res.code_point      = '0;
        res.status          = utd_pkg::ST_OK;
        res.final_res       = 1'b1;

        if (halted_reg)
        begin
            if (end_of_string)
            begin
                halted_next      = 1'b0;
                seq_length_next  = '0;
                bytes_taken_next = '0;
                payload_acc_next = '0;
            end
        end
        else if (seq_length_reg == '0)
        begin
            if (!byte_in[7])
            begin
                res_valid      = 1'b1;
                res.code_point = {23'd0, byte_in};
                res.final_res  = end_of_string;
            end
            else if (lead_bad || end_of_string)
            begin
                res_valid   = 1'b1;
                res.status  = lead_bad ? utd_pkg::ST_BAD_LEAD : utd_pkg::ST_TRUNCATED;
                halted_next = !end_of_string;
            end
            else
            begin
                seq_length_next  = lead_len;
                bytes_taken_next = 3'd1;
                payload_acc_next = lead_bits;
            end
        end
        else if (taken_inc >= seq_length_reg)
        begin
            res_valid        = 1'b1;
            seq_length_next  = '0;
            bytes_taken_next = '0;
            payload_acc_next = '0;
            if (acc_shift >= utd_pkg::SURR_LO && acc_shift <= utd_pkg::SURR_HI)
            begin
                res.status  = utd_pkg::ST_SURROGATE;
                halted_next = !end_of_string;
            end
            else
            begin
                res.code_point = acc_shift;
                res.final_res  = end_of_string;
            end
        end
        else if (end_of_string)
        begin
            res_valid        = 1'b1;
            res.status       = utd_pkg::ST_TRUNCATED;
            seq_length_next  = '0;
            bytes_taken_next = '0;
            payload_acc_next = '0;
        end
        else
        begin
            bytes_taken_next = taken_inc;
            payload_acc_next = acc_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg  <= '0;
            bytes_taken_reg <= '0;
            payload_acc_reg <= '0;
            halted_reg      <= 1'b0;
        end
        else if (accept)
        begin
            seq_length_reg  <= seq_length_next;
            bytes_taken_reg <= bytes_taken_next;
            payload_acc_reg <= payload_acc_next;
            halted_reg      <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utd_out_reg.sv =====
`default_nettype none

module utd_out_reg
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                res_valid,
    input  wire utd_pkg::result_t    res,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output utd_pkg::result_t         out_res
);

    logic               valid_reg;
    logic               valid_next;
    utd_pkg::result_t   data_reg;
    logic               load;

    assign load     = accept && res_valid;
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 237;
    localparam int CP_W        = utd_pkg::CP_W;
    localparam int LEN_W       = utd_pkg::LEN_W;

    class utf8_decode_board;
        logic [LEN_W-1:0]   seq_len;
        logic [LEN_W-1:0]   taken;
        logic [CP_W-1:0]    acc;
        bit                 halted;
        utd_pkg::result_t   decoded_queue[$];
        int                 mismatches;
        int                 checked;
        int                 error_results;
        int                 bytes_seen;
        int                 strings_seen;

        function new();
            drop_sequence();
            halted = 1'b0;
            mismatches = 0;
            checked = 0;
            error_results = 0;
            bytes_seen = 0;
            strings_seen = 0;
        endfunction

        function void drop_sequence();
            seq_len = '0;
            taken = '0;
            acc = '0;
        endfunction

        function void push_char(logic [CP_W-1:0] cp, utd_pkg::status_t st, logic fin);
            utd_pkg::result_t r;
            r.code_point = cp;
            r.status = st;
            r.final_res = fin;
            decoded_queue.insert(decoded_queue.size(), r);
        endfunction

        // An error ends the string; without the last flag the rest of it is skipped.
        function void raise_error(utd_pkg::status_t st, logic eos);
            drop_sequence();
            halted = !eos;
            error_results++;
            push_char('0, st, 1'b1);
        endfunction

        function void predict_byte(logic [7:0] b, logic eos);
            logic [LEN_W-1:0] len;
            logic [CP_W-1:0]  bits;
            bytes_seen++;
            if (eos)
                strings_seen++;
            if (halted)
            begin
                if (eos)
                begin
                    halted = 1'b0;
                    drop_sequence();
                end
                return;
            end
            if (seq_len == '0)
            begin
                len = '0;
                bits = '0;
                casez (b)
                    8'b0???????:
                    begin
                        push_char(CP_W'(b), utd_pkg::ST_OK, eos);
                        return;
                    end
                    8'b110?????:
                    begin
                        len = 3'd2;
                        bits = CP_W'(b[4:0]);
                    end
                    8'b1110????:
                    begin
                        len = 3'd3;
                        bits = CP_W'(b[3:0]);
                    end
                    8'b11110???:
                    begin
                        len = 3'd4;
                        bits = CP_W'(b[2:0]);
                    end
                    8'b111110??:
                    begin
                        len = 3'd5;
                        bits = CP_W'(b[1:0]);
                    end
                    8'b1111110?:
                    begin
                        len = 3'd6;
                        bits = CP_W'(b[0]);
                    end
                    default:
                    begin
                        raise_error(utd_pkg::ST_BAD_LEAD, eos);
                        return;
                    end
                endcase
                if (eos)
                    raise_error(utd_pkg::ST_TRUNCATED, eos);
                else
                begin
                    seq_len = len;
                    taken = 3'd1;
                    acc = bits;
                end
                return;
            end
            acc = {acc[CP_W-7:0], b[5:0]};
            taken = taken + 3'd1;
            if (taken >= seq_len)
            begin
                if (acc >= utd_pkg::SURR_LO && acc <= utd_pkg::SURR_HI)
                    raise_error(utd_pkg::ST_SURROGATE, eos);
                else
                begin
                    push_char(acc, utd_pkg::ST_OK, eos);
                    drop_sequence();
                end
            end
            else if (eos)
                raise_error(utd_pkg::ST_TRUNCATED, eos);
        endfunction

        function void check_decoded(logic [31:0] data, logic [1:0] user, logic last);
            utd_pkg::result_t e;
            if (decoded_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got code_point %h %s %0d %s %b",
                         $time, data, "status", user, "last", last);
                return;
            end
            e = decoded_queue.pop_front();
            checked++;
            if (data !== {1'b0, e.code_point})
            begin
                mismatches++;
                $display("%0t: code_point expected %h, got %h", $time, {1'b0, e.code_point}, data);
            end
            if (user !== e.status)
            begin
                mismatches++;
                $display("%0t: status expected %0d, got %0d", $time, e.status, user);
            end
            if (last !== e.final_res)
            begin
                mismatches++;
                $display("%0t: final_res expected %b, got %b", $time, e.final_res, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf8_decode_board board = new();

    int          idle_cycles = 0;
    int          bytes_sent = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          phase_target;
    logic [8:0]  burst[$];

    int          idle_plan[4] = '{0, 80, 0, 12};
    int          stall_plan[4] = '{0, 0, 80, 12};

    // Each entry is {end_of_string, byte}.
    logic [8:0]  opening[24] = '{
        9'h000, 9'h17F, 9'h0C2, 9'h029, 9'h0EF, 9'h0BF, 9'h1BF, 9'h0ED,
        9'h0A0, 9'h080, 9'h041, 9'h142, 9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h0BF, 9'h1BF, 9'h1FE, 9'h1F8, 9'h0F0, 9'h190, 9'h080, 9'h1C0
    };

    utf8_to_utf32_decoder_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            board.predict_byte(s_tdata, s_tlast);
        if (m_tvalid && m_tready)
            board.check_decoded(m_tdata, m_tuser, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("utf8_to_utf32_decoder_unit regression: fail");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic flush_burst();
        logic [8:0] item;
        while (burst.size() > 0)
        begin
            item = burst.pop_front();
            send_byte(item[7:0], item[8]);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.decoded_queue.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed characters of every length, with some noise bytes,
    // strings cut inside a sequence, surrogate values and odd continuation tops.
    task automatic make_string();
        int          nchars;
        int          kind;
        int          len;
        int          w;
        int          cut;
        logic [30:0] v;
        logic [30:0] part;
        logic [7:0]  b;
        nchars = $urandom_range(1, 6);
        for (int c = 0; c < nchars; c++)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                burst.insert(burst.size(), {1'($urandom_range(3) == 0), 8'($urandom)});
                continue;
            end
            len = (kind < 40) ? 1 : $urandom_range(2, 6);
            w = (len == 1) ? 7 : 5 * len + 1;
            v = 31'($urandom) & 31'((64'd1 << w) - 1);
            if (len >= 3 && $urandom_range(14) == 0)
                v = 31'h0000_D800 | 31'($urandom_range(16'h07FF));
            cut = ($urandom_range(19) == 0) ? $urandom_range(1, len) : 0;
            if (len == 1)
                b = {1'b0, v[6:0]};
            else
            begin
                part = v >> (6 * (len - 1));
                b = (8'hFF << (8 - len)) | part[7:0];
            end
            burst.insert(burst.size(), {1'(cut == 1), b});
            if (cut == 1)
                return;
            for (int k = 1; k < len; k++)
            begin
                part = v >> (6 * (len - 1 - k));
                b = {2'b10, part[5:0]};
                if ($urandom_range(9) == 0)
                    b[7:6] = 2'($urandom);
                burst.insert(burst.size(), {1'(cut == k + 1), b});
                if (cut == k + 1)
                    return;
            end
        end
        burst[$][8] = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            burst.insert(burst.size(), opening[i]);
        flush_burst();
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_plan[p];
            stall_pct = stall_plan[p];
            phase_target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_target)
            begin
                make_string();
                flush_burst();
            end
            drain_results();
        end
        stall_pct = 0;

        repeat (10) @(posedge clk);
        $display("Decoded %0d bytes in %0d strings and checked %0d results, %0d of them errors.",
                 board.bytes_seen, board.strings_seen, board.checked, board.error_results);
        $display("Phases ran with no idling, an idle sender, a stalling receiver, and both.");
        if (board.mismatches == 0 && board.decoded_queue.size() == 0)
            $display("utf8_to_utf32_decoder_unit regression: pass");
        else
            $display("utf8_to_utf32_decoder_unit regression: fail");
        $finish;
    end

endmodule
